// ===== hdl/bdsu_pkg.sv =====
// Shared types and constants for the divide / square root service unit.
`timescale 1ns / 1ps
`default_nettype none
package bdsu_pkg;

	localparam int WORD_W = 32;
	localparam int CMD_W  = 2;
	localparam int ROOT_W = WORD_W / 2;
	localparam int SUB_W  = WORD_W + 2;
	localparam int CNT_W  = 5;

	localparam logic [CMD_W-1:0] CMD_DIVIDE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SWAPPED = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ROOT    = 2'd2;

	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(WORD_W - 1);
	localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_W - 1);

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [WORD_W-1:0] first_operand;
		logic [WORD_W-1:0] second_operand;
	} bdsu_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_zero;
		logic [WORD_W-1:0] result_one;
		logic [WORD_W-1:0] result_three;
		logic              write_zero;
		logic              write_one_three;
		logic              zero_divisor;
	} bdsu_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/bdsu_if.sv =====
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
`default_nettype none
interface bdsu_req_if import bdsu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [WORD_W-1:0] first_operand;
	logic [WORD_W-1:0] second_operand;

	modport source (output valid, cmd, first_operand, second_operand, input ready);
	modport sink   (input valid, cmd, first_operand, second_operand, output ready);
endinterface

interface bdsu_rsp_if import bdsu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] result_zero;
	logic [WORD_W-1:0] result_one;
	logic [WORD_W-1:0] result_three;
	logic              write_zero;
	logic              write_one_three;
	logic              zero_divisor;

	modport source (output valid, result_zero, result_one, result_three, write_zero,
		write_one_three, zero_divisor, input ready);
	modport sink   (input valid, result_zero, result_one, result_three, write_zero,
		write_one_three, zero_divisor, output ready);
endinterface
`default_nettype wire

// ===== hdl/bios_divide_sqrt_unit.sv =====
// Signed divide and integer square root service unit, top level.
//
// Channels: req carries cmd, first_operand and second_operand; rsp carries
// the new r0, r1 and r3 values with their write strobes and the zero divisor
// flag. Both use valid/ready; a transfer happens when valid and ready are high.
// cmd 0 divides first by second, 1 divides second by first, 2 takes the floor
// square root of first_operand; cmd 3 yields an all-zero result.
// A divide runs 32 restoring steps on the shared 34-bit subtractor, then
// a sign fix-up and a hand-off to the rsp register; a square root runs 16
// steps, then a fix-up and the hand-off. A zero divisor or cmd 3 goes
// straight to the hand-off. req.ready is high only while the engine is idle,
// so one request is in flight and the next is taken only after the hand-off.
// A finished result sits in the rsp output register; the engine may finish
// the next request meanwhile and then waits until that register frees up.
// Reset clears all control state; no request or result survives it.
`timescale 1ns / 1ps
`default_nettype none
module bios_divide_sqrt_unit import bdsu_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	bdsu_req_if.sink    req,
	bdsu_rsp_if.source  rsp
);

	bdsu_req_t core_req;
	bdsu_rsp_t core_res;
	bdsu_rsp_t rsp_q;
	logic      rsp_valid_q;
	logic      core_idle;
	logic      core_done;
	logic      core_take;

	assign core_req.cmd            = req.cmd;
	assign core_req.first_operand  = req.first_operand;
	assign core_req.second_operand = req.second_operand;

	assign req.ready = core_idle;
	assign core_take = core_done && (!rsp_valid_q || rsp.ready);

	bdsu_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (req.valid),
		.req    (core_req),
		.idle   (core_idle),
		.done   (core_done),
		.take   (core_take),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (core_take) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= core_res;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.result_zero     = rsp_q.result_zero;
	assign rsp.result_one      = rsp_q.result_one;
	assign rsp.result_three    = rsp_q.result_three;
	assign rsp.write_zero      = rsp_q.write_zero;
	assign rsp.write_one_three = rsp_q.write_one_three;
	assign rsp.zero_divisor    = rsp_q.zero_divisor;

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while engine busy");

	a_zdiv_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.zero_divisor) |-> (!rsp.write_zero && !rsp.write_one_three))
		else $error("zero divisor result carries a write strobe");

	a_w13_implies_w0: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.write_one_three) |-> rsp.write_zero)
		else $error("r1/r3 written without r0");

	a_root_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.write_zero && !rsp.write_one_three)
		|-> (rsp.result_zero[WORD_W-1:ROOT_W] == '0))
		else $error("square root wider than half a word");

endmodule
`default_nettype wire

// ===== hdl/bdsu_core.sv =====
// Iterative shift-subtract engine shared by divide and square root.
`timescale 1ns / 1ps
`default_nettype none
module bdsu_core import bdsu_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire bdsu_req_t req,
	output logic           idle,
	output logic           done,
	input  wire logic      take,
	output bdsu_rsp_t      res
);

	typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_FIX, ST_DONE} state_t;

	state_t            state_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] wrk_q;
	logic [WORD_W-1:0] div_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              sqrt_q;
	logic              neg_q;
	logic              num_neg_q;
	bdsu_rsp_t         res_q;

	logic [WORD_W-1:0] num;
	logic [WORD_W-1:0] den;
	logic [SUB_W-1:0]  sub_a;
	logic [SUB_W-1:0]  sub_b;
	logic [SUB_W-1:0]  diff;
	logic              ge;

	function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] v);
		return v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
	endfunction

	assign num = (req.cmd == CMD_SWAPPED) ? req.second_operand : req.first_operand;
	assign den = (req.cmd == CMD_SWAPPED) ? req.first_operand : req.second_operand;

	// single shared subtractor
	always_comb begin
		if (sqrt_q) begin
			sub_a = {{(SUB_W-ROOT_W-3){1'b0}}, acc_q[ROOT_W:0], wrk_q[WORD_W-1 -: 2]};
			sub_b = {{(SUB_W-ROOT_W-2){1'b0}}, root_q, 2'b01};
		end else begin
			sub_a = {1'b0, acc_q, wrk_q[WORD_W-1]};
			sub_b = {2'b00, div_q};
		end
		diff = sub_a - sub_b;
		ge   = ~diff[SUB_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			acc_q     <= '0;
			wrk_q     <= '0;
			div_q     <= '0;
			root_q    <= '0;
			cnt_q     <= '0;
			sqrt_q    <= 1'b0;
			neg_q     <= 1'b0;
			num_neg_q <= 1'b0;
			res_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						acc_q  <= '0;
						root_q <= '0;
						res_q  <= '0;
						if (req.cmd == CMD_ROOT) begin
							sqrt_q  <= 1'b1;
							wrk_q   <= req.first_operand;
							cnt_q   <= ROOT_LAST;
							state_q <= ST_CALC;
						end else if (req.cmd == CMD_DIVIDE || req.cmd == CMD_SWAPPED) begin
							if (den == '0) begin
								res_q.zero_divisor <= 1'b1;
								state_q            <= ST_DONE;
							end else begin
								sqrt_q    <= 1'b0;
								wrk_q     <= mag(num);
								div_q     <= mag(den);
								neg_q     <= num[WORD_W-1] ^ den[WORD_W-1];
								num_neg_q <= num[WORD_W-1];
								cnt_q     <= DIV_LAST;
								state_q   <= ST_CALC;
							end
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_CALC: begin
					acc_q <= ge ? diff[WORD_W-1:0] : sub_a[WORD_W-1:0];
					if (sqrt_q) begin
						wrk_q  <= {wrk_q[WORD_W-3:0], 2'b00};
						root_q <= {root_q[ROOT_W-2:0], ge};
					end else begin
						wrk_q <= {wrk_q[WORD_W-2:0], ge};
					end
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					if (sqrt_q) begin
						res_q.result_zero <= {{(WORD_W-ROOT_W){1'b0}}, root_q};
						res_q.write_zero  <= 1'b1;
					end else begin
						res_q.result_zero     <= neg_q ? (~wrk_q + WORD_W'(1)) : wrk_q;
						res_q.result_one      <= num_neg_q ? (~acc_q + WORD_W'(1)) : acc_q;
						res_q.result_three    <= wrk_q;
						res_q.write_zero      <= 1'b1;
						res_q.write_one_three <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idle = (state_q == ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign res  = res_q;

endmodule
`default_nettype wire

// ===== tb/sv/bios_divide_sqrt_unit_tb.sv =====
// Self-checking testbench for the signed divide / floor square root service unit.
`timescale 1ns / 1ps
`default_nettype none
module bios_divide_sqrt_unit_tb;
	import bdsu_pkg::*;

	localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
	localparam logic [WORD_W-1:0] WORD_MIN    = 32'h8000_0000;
	localparam logic [WORD_W-1:0] WORD_MAX    = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;
	localparam int                RANDOM_CALLS = 850;
	localparam int                QUIET_LIMIT = 4000;
	localparam int                TAIL_CYCLES = 60;

	typedef struct {
		bdsu_req_t req;
		bit        drain_first;
	} queued_call_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bdsu_req_if req_ch ();
	bdsu_rsp_if rsp_ch ();

	bios_divide_sqrt_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	queued_call_t pending_calls[$];
	bdsu_rsp_t    awaited_replies[$];

	int errors = 0;
	int replies_seen = 0;
	int zero_div_seen = 0;
	int served[4] = '{0, 0, 0, 0};
	int send_gap = 0;
	int send_pct = 0;
	int send_draws = 0;
	int sink_stall = 0;
	int sink_pct = 0;
	int sink_draws = 0;

	queued_call_t next_call;
	bdsu_req_t    taken_req;
	bdsu_rsp_t    got_reply;
	bdsu_rsp_t    want_reply;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result of one service call, computed independently of the engine.
	function automatic bdsu_rsp_t math_service(bdsu_req_t r);
		bdsu_rsp_t         o;
		logic [WORD_W-1:0] num;
		logic [WORD_W-1:0] den;
		logic [WORD_W-1:0] mag_n;
		logic [WORD_W-1:0] mag_d;
		logic [WORD_W-1:0] quo;
		logic [WORD_W-1:0] rem;
		logic [ROOT_W-1:0] root;
		logic [ROOT_W-1:0] trial;
		logic [2*WORD_W-1:0] sq;
		o = '0;
		case (r.cmd)
		CMD_DIVIDE, CMD_SWAPPED: begin
			num = (r.cmd == CMD_DIVIDE) ? r.first_operand : r.second_operand;
			den = (r.cmd == CMD_DIVIDE) ? r.second_operand : r.first_operand;
			if (den == '0) begin
				o.zero_divisor = 1'b1;
			end else begin
				mag_n = num[WORD_W-1] ? -num : num;
				mag_d = den[WORD_W-1] ? -den : den;
				quo = mag_n / mag_d;
				rem = mag_n % mag_d;
				o.result_three = quo;
				o.result_zero = (num[WORD_W-1] ^ den[WORD_W-1]) ? -quo : quo;
				o.result_one = num[WORD_W-1] ? -rem : rem;
				o.write_zero = 1'b1;
				o.write_one_three = 1'b1;
			end
		end
		CMD_ROOT: begin
			root = '0;
			for (int i = ROOT_W - 1; i >= 0; i--) begin
				trial = root | (ROOT_W'(1) << i);
				sq = (2*WORD_W)'(trial) * (2*WORD_W)'(trial);
				if (sq <= (2*WORD_W)'(r.first_operand))
					root = trial;
			end
			o.result_zero = WORD_W'(root);
			o.write_zero = 1'b1;
		end
		default: ;
		endcase
		return o;
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(2))
		0: return 0;
		1: return 15;
		default: return 45;
		endcase
	endfunction

	// Mostly short idles, a few long ones.
	function automatic int draw_idle(int pct);
		int roll;
		if ($urandom_range(99) >= pct)
			return 0;
		roll = $urandom_range(99);
		if (roll < 70)
			return $urandom_range(3, 1);
		if (roll < 93)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic [WORD_W-1:0] draw_operand();
		logic [WORD_W-1:0] v;
		case ($urandom_range(9))
		0, 1, 2, 3: v = $urandom();
		4, 5: v = $urandom_range(600) - 300;
		6: case ($urandom_range(4))
			0: v = '0;
			1: v = 32'd1;
			2: v = ALL_ONES;
			3: v = WORD_MIN;
			default: v = WORD_MAX;
		endcase
		7, 8: begin
			v = $urandom() >> $urandom_range(31);
			if ($urandom_range(1))
				v = -v;
		end
		default: v = $urandom_range(1) ? WORD_MIN + $urandom_range(7) : WORD_MAX - $urandom_range(7);
		endcase
		return v;
	endfunction

	function automatic logic [WORD_W-1:0] draw_radicand();
		logic [WORD_W-1:0] v;
		logic [WORD_W-1:0] base;
		case ($urandom_range(3))
		0: v = $urandom();
		1: v = $urandom() >> $urandom_range(31);
		default: begin
			base = $urandom_range(16'hFFFF);
			v = base * base + $urandom_range(2) - 1;
		end
		endcase
		return v;
	endfunction

	task automatic queue_call(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] a,
		logic [WORD_W-1:0] b, bit drain);
		queued_call_t c;
		c.req.cmd = cmd;
		c.req.first_operand = a;
		c.req.second_operand = b;
		c.drain_first = drain;
		pending_calls.push_back(c);
	endtask

	task automatic report(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
		$display("%0t: %s expected %h actual %h", $time, field, want, got);
		errors++;
	endtask

	// Request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.cmd <= '0;
			req_ch.first_operand <= '0;
			req_ch.second_operand <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				taken_req.cmd = req_ch.cmd;
				taken_req.first_operand = req_ch.first_operand;
				taken_req.second_operand = req_ch.second_operand;
				awaited_replies.push_back(math_service(taken_req));
				served[taken_req.cmd]++;
			end
			if (req_ch.valid && !req_ch.ready) begin
				// hold until the transfer
			end else if (send_gap > 0) begin
				send_gap--;
				req_ch.valid <= 1'b0;
			end else if (pending_calls.size() > 0 &&
				!(pending_calls[0].drain_first && awaited_replies.size() > 0)) begin
				next_call = pending_calls.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.cmd <= next_call.req.cmd;
				req_ch.first_operand <= next_call.req.first_operand;
				req_ch.second_operand <= next_call.req.second_operand;
				if (send_draws % 40 == 0)
					send_pct = pick_pct();
				send_draws++;
				send_gap = draw_idle(send_pct);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Result monitor and sink
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_reply.result_zero = rsp_ch.result_zero;
				got_reply.result_one = rsp_ch.result_one;
				got_reply.result_three = rsp_ch.result_three;
				got_reply.write_zero = rsp_ch.write_zero;
				got_reply.write_one_three = rsp_ch.write_one_three;
				got_reply.zero_divisor = rsp_ch.zero_divisor;
				replies_seen++;
				if (got_reply.zero_divisor)
					zero_div_seen++;
				if (awaited_replies.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time,
						got_reply);
					errors++;
				end else begin
					want_reply = awaited_replies.pop_front();
					if (got_reply.result_zero !== want_reply.result_zero)
						report("result_zero", want_reply.result_zero, got_reply.result_zero);
					if (got_reply.result_one !== want_reply.result_one)
						report("result_one", want_reply.result_one, got_reply.result_one);
					if (got_reply.result_three !== want_reply.result_three)
						report("result_three", want_reply.result_three, got_reply.result_three);
					if (got_reply.write_zero !== want_reply.write_zero)
						report("write_zero", WORD_W'(want_reply.write_zero),
							WORD_W'(got_reply.write_zero));
					if (got_reply.write_one_three !== want_reply.write_one_three)
						report("write_one_three", WORD_W'(want_reply.write_one_three),
							WORD_W'(got_reply.write_one_three));
					if (got_reply.zero_divisor !== want_reply.zero_divisor)
						report("zero_divisor", WORD_W'(want_reply.zero_divisor),
							WORD_W'(got_reply.zero_divisor));
				end
			end
			if (sink_stall > 0) begin
				sink_stall--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (sink_draws % 200 == 0)
					sink_pct = pick_pct() / 3;
				sink_draws++;
				sink_stall = draw_idle(sink_pct);
			end
		end
	end

	// Ends the run when no transfer happens for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: timeout with %0d results outstanding", $time, awaited_replies.size());
		$display("bios_divide_sqrt_unit: mismatch");
		$finish;
	end

	initial begin
		logic [CMD_W-1:0] cmd;
		int               roll;
		req_ch.valid = 1'b0;
		req_ch.cmd = '0;
		req_ch.first_operand = '0;
		req_ch.second_operand = '0;
		rsp_ch.ready = 1'b0;

		// signs, truncation, zero divisor, most negative over minus one
		queue_call(CMD_DIVIDE, 32'd7, 32'd2, 1'b0);
		queue_call(CMD_DIVIDE, -32'd7, 32'd2, 1'b0);
		queue_call(CMD_DIVIDE, 32'd7, -32'd2, 1'b0);
		queue_call(CMD_DIVIDE, -32'd7, -32'd2, 1'b0);
		queue_call(CMD_DIVIDE, WORD_MIN, ALL_ONES, 1'b0);
		queue_call(CMD_DIVIDE, WORD_MIN, 32'd1, 1'b0);
		queue_call(CMD_DIVIDE, WORD_MAX, ALL_ONES, 1'b0);
		queue_call(CMD_DIVIDE, ALL_ONES, WORD_MIN, 1'b0);
		queue_call(CMD_DIVIDE, WORD_MIN, WORD_MIN, 1'b0);
		queue_call(CMD_DIVIDE, 32'd5, WORD_MAX, 1'b0);
		queue_call(CMD_DIVIDE, 32'd123, '0, 1'b0);
		queue_call(CMD_DIVIDE, '0, '0, 1'b0);
		queue_call(CMD_DIVIDE, '0, 32'd5, 1'b0);
		queue_call(CMD_SWAPPED, 32'd2, 32'd7, 1'b0);
		queue_call(CMD_SWAPPED, '0, WORD_MAX, 1'b0);
		queue_call(CMD_SWAPPED, ALL_ONES, WORD_MIN, 1'b0);
		queue_call(CMD_SWAPPED, -32'd3, 32'd100, 1'b0);
		queue_call(CMD_ROOT, '0, $urandom(), 1'b0);
		queue_call(CMD_ROOT, 32'd1, $urandom(), 1'b0);
		queue_call(CMD_ROOT, 32'd3, ALL_ONES, 1'b0);
		queue_call(CMD_ROOT, ALL_ONES, $urandom(), 1'b0);
		queue_call(CMD_ROOT, 32'hFFFE_0001, $urandom(), 1'b0);
		queue_call(CMD_ROOT, 32'h3FFF_FFFF, $urandom(), 1'b0);
		queue_call(CMD_UNUSED, ALL_ONES, ALL_ONES, 1'b0);
		queue_call(CMD_UNUSED, $urandom(), $urandom(), 1'b0);

		for (int k = 0; k < RANDOM_CALLS; k++) begin
			roll = $urandom_range(99);
			if (roll < 40)
				cmd = CMD_DIVIDE;
			else if (roll < 70)
				cmd = CMD_SWAPPED;
			else if (roll < 95)
				cmd = CMD_ROOT;
			else
				cmd = CMD_UNUSED;
			// every so often the sender waits for all results to drain
			if (cmd == CMD_ROOT)
				queue_call(cmd, draw_radicand(), $urandom(), k % 170 == 0);
			else
				queue_call(cmd, draw_operand(), draw_operand(), k % 170 == 0);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_calls.size() != 0 || req_ch.valid || awaited_replies.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run: %0d divides, %0d swapped divides, %0d roots, %0d unused codes",
			served[CMD_DIVIDE], served[CMD_SWAPPED], served[CMD_ROOT], served[CMD_UNUSED]);
		$display("run: %0d results checked, %0d with zero divisor, %0d errors",
			replies_seen, zero_div_seen, errors);
		if (errors == 0)
			$display("bios_divide_sqrt_unit: match");
		else
			$display("bios_divide_sqrt_unit: mismatch");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/bdsu_pkg.sv
hdl/bdsu_if.sv
hdl/bdsu_core.sv
hdl/bios_divide_sqrt_unit.sv
tb/sv/bios_divide_sqrt_unit_tb.sv
